// ----- sv/rbat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbat_pkg: shared types and constants for the ascending time ranker
// Field widths, the queue item passed from the front to the back, and the
// state encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package rbat_pkg;

  localparam int TIME_W    = 32;
  localparam int POS_W     = 6;
  localparam int RANK_W    = 7;
  localparam int GRP_SZ    = 8;
  localparam int GRP_CNT_W = 4;

  // One queued time, already classified as ending the set or not.
  typedef struct packed {
    logic [TIME_W-1:0] time_value;
    logic              set_end;
  } rbat_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COUNT,
    BK_UPD,
    BK_EMIT
  } rbat_bk_state_t;

endpackage

// ----- sv/rbat_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbat_in_if: input channel of the ascending time ranker
// Valid/ready channel carrying one time and its end-of-set marker per beat.
// ----------------------------------------------------------------------------
interface rbat_in_if;
  import rbat_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_value;
  logic              last_item;

  modport source (output valid, output time_value, output last_item, input ready);
  modport sink   (input valid, input time_value, input last_item, output ready);

endinterface

// ----- sv/rbat_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbat_out_if: result channel of the ascending time ranker
// Valid/ready channel carrying one entry position and its rank per beat.
// ----------------------------------------------------------------------------
interface rbat_out_if;
  import rbat_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  entry_position;
  logic [RANK_W-1:0] entry_rank;
  logic              last_result;

  modport source (output valid, output entry_position, output entry_rank,
                  output last_result, input ready);
  modport sink   (input valid, input entry_position, input entry_rank,
                  input last_result, output ready);

endinterface

// ----- sv/rank_by_ascending_time.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_by_ascending_time: stable ascending rank of a set of times
// Loads up to ENTRIES times and reports each entry's 1-based rank in load
// order once the set ends.
// ----------------------------------------------------------------------------
// Each input beat carries one unsigned time (16 fraction bits). A set ends at
// the beat with last_item set, or at the ENTRIES-th beat, whichever is first;
// that beat then yields one result beat per loaded entry, in load order, with
// the entry's rank by ascending time, equal times ranked by load order. A time
// passes through the rank array in order: compare against every stored cell,
// count in groups of eight, then sum and update all ranks; the array takes no
// new time until it is done, while a two-entry queue in front of the array
// keeps taking beats. Ending a set then shifts the ranks out of the array,
// one result beat per cycle while the sink is ready. There is no clearing
// pass after reset: the block takes beats from the first cycle out of reset.
// ----------------------------------------------------------------------------
module rank_by_ascending_time #(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rbat_in_if.sink    in_ch,
  rbat_out_if.source out_ch
);
  import rbat_pkg::*;

  // Classified times travel from the front end to the rank array through
  // this queue port; each side stalls on its own.
  rbat_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  // The front end counts the beats of the current set, so it knows which
  // beat ends the set before the array has processed anything.
  rbat_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // The back end holds the stored times and running ranks, and owns the
  // registered result stage.
  rbat_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

// ----- sv/rbat_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbat_front: input acceptance and set classification
// Marks each accepted time as ending the set or not and holds it in a
// two-entry queue until the rank array takes it.
// ----------------------------------------------------------------------------
module rbat_front #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  rbat_in_if.sink             in_ch,
  output rbat_pkg::rbat_item_t q_item,
  output logic                q_valid,
  input  logic                q_ready
);
  import rbat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  rbat_item_t       qmem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       qcnt_r, qcnt_nxt;
  logic [IDX_W-1:0] fcnt_r, fcnt_nxt;
  logic             push, pop, set_end;

  assign in_ch.ready = (qcnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (qcnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = qmem_r[rd_ptr_r];

  // The set also ends when the store is about to be full.
  assign set_end = in_ch.last_item || (fcnt_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    qcnt_nxt   = qcnt_r + {1'b0, push} - {1'b0, pop};
    fcnt_nxt   = fcnt_r;
    if (push) begin
      fcnt_nxt = set_end ? '0 : fcnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      qcnt_r   <= 2'd0;
      fcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      qcnt_r   <= qcnt_nxt;
      fcnt_r   <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r].time_value <= in_ch.time_value;
      qmem_r[wr_ptr_r].set_end    <= set_end;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r != 2'd3)
    else $error("front queue count out of range");

  a_set_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && set_end) |=> (fcnt_r == '0))
    else $error("set counter did not restart after an ending beat");

endmodule

// ----- sv/rbat_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbat_back: rank array and result sequencer
// Compares each queued time against every stored cell, keeps the running
// ranks up to date and, once a set ends, shifts the ranks out in load order.
// ----------------------------------------------------------------------------
module rbat_back #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbat_pkg::rbat_item_t q_item,
  input  logic                 q_valid,
  output logic                 q_ready,
  rbat_out_if.source           out_ch
);
  import rbat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int NGRP  = (ENTRIES + GRP_SZ - 1) / GRP_SZ;

  rbat_bk_state_t     st_r, st_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   emit_idx_r, emit_idx_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [TIME_W-1:0]    time_r [ENTRIES];
  logic [RANK_W-1:0]    rank_r [ENTRIES];
  logic                 cur_end_r;
  logic [ENTRIES-1:0]   le_r, le_now;
  logic [GRP_CNT_W-1:0] grp_r [NGRP];
  logic [GRP_CNT_W-1:0] grp_now [NGRP];
  logic [POS_W-1:0]     out_pos_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic                 out_last_r;

  logic               cap, do_upd, do_emit, out_load, emit_last;
  logic [RANK_W-1:0]  new_rank;
  logic [IDX_W-1:0]   wr_idx;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.entry_position = out_pos_r;
  assign out_ch.entry_rank     = out_rank_r;
  assign out_ch.last_result    = out_last_r;

  assign out_load  = !out_valid_r || out_ch.ready;
  assign emit_last = ((CNT_W'(emit_idx_r) + CNT_W'(1)) == n_r);
  assign wr_idx    = n_r[IDX_W-1:0];

  // Stored times less than or equal to the new one; unloaded cells masked.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      le_now[i] = (CNT_W'(i) < n_r) && (time_r[i] <= q_item.time_value);
    end
  end

  // Population count in groups of eight, then a short sum of the groups.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_now[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if (g * GRP_SZ + j < ENTRIES) begin
          grp_now[g] = grp_now[g] + GRP_CNT_W'(le_r[g * GRP_SZ + j]);
        end
      end
    end
  end

  always_comb begin
    new_rank = RANK_W'(1);
    for (int g = 0; g < NGRP; g++) begin
      new_rank = new_rank + RANK_W'(grp_r[g]);
    end
  end

  always_comb begin
    case (st_r)
      BK_IDLE:  st_nxt = q_valid ? BK_COUNT : BK_IDLE;
      BK_COUNT: st_nxt = BK_UPD;
      BK_UPD:   st_nxt = cur_end_r ? BK_EMIT : BK_IDLE;
      BK_EMIT:  st_nxt = (out_load && emit_last) ? BK_IDLE : BK_EMIT;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (st_r == BK_IDLE);
    cap     = q_ready && q_valid;
    do_upd  = (st_r == BK_UPD);
    do_emit = (st_r == BK_EMIT) && out_load;

    n_nxt = n_r;
    if (do_upd) begin
      n_nxt = n_r + CNT_W'(1);
    end else if (do_emit && emit_last) begin
      n_nxt = '0;
    end

    emit_idx_nxt = emit_idx_r;
    if (do_emit) begin
      emit_idx_nxt = emit_last ? '0 : emit_idx_r + IDX_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (do_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      n_r         <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      n_r         <= n_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      cur_end_r <= q_item.set_end;
      le_r      <= le_now;
      time_r[wr_idx] <= q_item.time_value;
    end
    if (st_r == BK_COUNT) begin
      grp_r <= grp_now;
    end
    if (do_upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == wr_idx) begin
          rank_r[i] <= new_rank;
        end else if ((CNT_W'(i) < n_r) && !le_r[i]) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (do_emit) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        rank_r[i] <= rank_r[i + 1];
      end
      out_pos_r  <= POS_W'(emit_idx_r);
      out_rank_r <= rank_r[0];
      out_last_r <= emit_last;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_UPD) |-> (n_r < CNT_W'(ENTRIES)))
    else $error("rank array written beyond its depth");

  a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_EMIT && out_load && emit_last) |=>
      (n_r == '0 && st_r == BK_IDLE && out_last_r))
    else $error("final beat of a set did not close the set");

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rank_r != '0 && out_rank_r <= RANK_W'(ENTRIES)))
    else $error("emitted rank out of range");

endmodule
